@@ sv/qau_pkg.sv @@
// shared types and codes for the quaternion arithmetic unit
`default_nettype none

package qau_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 12;

	typedef logic [3:0] mode_t;
	typedef logic [1:0] status_t;
	typedef logic [COMP_WIDTH-1:0] comp_t;

	localparam mode_t MODE_MUL   = 4'd0;
	localparam mode_t MODE_ADD   = 4'd1;
	localparam mode_t MODE_SUB   = 4'd2;
	localparam mode_t MODE_CONJ  = 4'd3;
	localparam mode_t MODE_INV   = 4'd4;
	localparam mode_t MODE_QDIV  = 4'd5;
	localparam mode_t MODE_SCALE = 4'd6;
	localparam mode_t MODE_ADIVS = 4'd7;
	localparam mode_t MODE_SDIVB = 4'd8;
	localparam mode_t MODE_NORM  = 4'd9;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_SAT  = 2'd1;
	localparam status_t ST_DIVZ = 2'd2;

	typedef struct packed {
		mode_t mode;
		comp_t a_x;
		comp_t a_y;
		comp_t a_z;
		comp_t a_w;
		comp_t b_x;
		comp_t b_y;
		comp_t b_z;
		comp_t b_w;
		comp_t scalar_s;
	} qau_in_t;

	typedef struct packed {
		comp_t   r_x;
		comp_t   r_y;
		comp_t   r_z;
		comp_t   r_w;
		status_t status;
	} qau_out_t;

endpackage

`default_nettype wire

@@ sv/quaternion_arithmetic_unit.sv @@
// quaternion arithmetic unit: pipelined product, sum, difference, conjugate, inverse, divide, scale and normalize
//
//  channel | direction | handshake             | word
//  cmd     | in        | cmd_valid / cmd_ready | qau_in_t  (mode, a, b, scalar_s)
//  res     | out       | res_valid / res_ready | qau_out_t (r, status)
//
// one word per cycle sustained while res_ready holds; each result passes through
// the 17-stage square root followed by the 16-stage restoring divider
// every mode runs the full pipe, so results come out in command order
// a stalled result sits in the output register, one more word lands in a skid register,
// then the whole pipe holds until the skid drains
// arst_n clears only valid bits; data registers are not reset
`default_nettype none

module quaternion_arithmetic_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  qau_pkg::qau_in_t  cmd_data,
	output logic              res_valid,
	input  logic              res_ready,
	output qau_pkg::qau_out_t res_data
);
	import qau_pkg::*;

	localparam int W      = COMP_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int QB     = W;
	localparam int ROOT_W = W + 1;
	localparam int DOT_W  = 2 * W + 1;
	localparam int RT_W   = 2 * W + 3;
	localparam int DEN_W  = 2 * W + 2;
	localparam int NUM_W  = ((W + 2 * F > 2 * W) ? W + 2 * F : 2 * W) + 2;
	localparam int REM_W  = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;
	localparam int PROD_W = 2 * W;
	localparam int SUM_W  = 2 * W + 3;

	localparam logic [W-1:0]     ONE     = W'(1) << F;
	localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (F - 1);
	localparam logic [W-1:0]     LIM_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]     LIM_NEG = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		mode_t              mode;
		logic [3:0][W-1:0] qa;
		logic [3:0][W-1:0] qb;
		logic [W-1:0]       s;
	} ctx_t;

	logic en;

	// output register and skid
	logic     res_valid_q;
	logic     skid_v_q;
	qau_out_t res_q;
	qau_out_t skid_q;

	assign en        = !skid_v_q;
	assign cmd_ready = en;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// stage 1: input capture
	logic    v_s1;
	qau_in_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_data;
		end
	end

	// stage 2: squares of the quaternion whose norm is needed
	ctx_t                     ctx_c;
	logic [3:0][W-1:0]        sel_c;
	logic signed [PROD_W-1:0] sq_c [4];
	logic                     v_s2;
	ctx_t                     ctx_s2;
	logic [PROD_W-1:0]        sq_s2 [4];

	always_comb begin
		ctx_c.mode = cmd_s1.mode;
		ctx_c.qa   = {cmd_s1.a_w, cmd_s1.a_z, cmd_s1.a_y, cmd_s1.a_x};
		ctx_c.qb   = {cmd_s1.b_w, cmd_s1.b_z, cmd_s1.b_y, cmd_s1.b_x};
		ctx_c.s    = cmd_s1.scalar_s;
		sel_c = (ctx_c.mode == MODE_INV || ctx_c.mode == MODE_NORM) ? ctx_c.qa : ctx_c.qb;
		for (int i = 0; i < 4; i++) begin
			sq_c[i] = $signed(sel_c[i]) * $signed(sel_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_c;
			for (int i = 0; i < 4; i++) begin
				sq_s2[i] <= sq_c[i];
			end
		end
	end

	// square root pipe, index 0 holds the dot product
	logic               rt_v_s    [ROOT_W+1];
	logic [RT_W-1:0]    rt_rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]  rt_root_s [ROOT_W+1];
	logic [DOT_W-1:0]   rt_dot_s  [ROOT_W+1];
	ctx_t               rt_ctx_s  [ROOT_W+1];
	logic [DOT_W-1:0]   dot_c;

	assign dot_c = DOT_W'(sq_s2[0]) + DOT_W'(sq_s2[1]) + DOT_W'(sq_s2[2]) + DOT_W'(sq_s2[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_rem_s[0]  <= RT_W'(dot_c);
			rt_root_s[0] <= '0;
			rt_dot_s[0]  <= dot_c;
			rt_ctx_s[0]  <= ctx_s2;
		end
	end

	for (genvar j = 1; j <= ROOT_W; j++) begin : g_rt
		localparam int B = ROOT_W - j;
		logic [RT_W-1:0] trial;
		logic            take;

		// (root + 2^b)^2 - root^2
		assign trial = (RT_W'(rt_root_s[j-1]) << (B + 1)) | (RT_W'(1) << (2 * B));
		assign take  = rt_rem_s[j-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[j] <= 1'b0;
			end else if (en) begin
				rt_v_s[j] <= rt_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[j]  <= take ? rt_rem_s[j-1] - trial : rt_rem_s[j-1];
				rt_root_s[j] <= rt_root_s[j-1] | ({{(ROOT_W-1){1'b0}}, take} << B);
				rt_dot_s[j]  <= rt_dot_s[j-1];
				rt_ctx_s[j]  <= rt_ctx_s[j-1];
			end
		end
	end

	// stage 4: divider operands
	ctx_t               su_ctx;
	logic               su_dvq_c;
	logic               su_err_c;
	logic [W:0]         su_sext_c;
	logic [W:0]         su_sabs_c;
	logic [DEN_W-2:0]   su_den_c;
	logic [W-1:0]       su_v_c [4];
	logic               su_f_c [4];
	logic [W:0]         su_c_c [4];
	logic [W:0]         su_mag_c [4];
	logic [NUM_W-1:0]   su_num_c [4];
	logic [NUM_W-1:0]   su_n_c [4];

	logic               su_v_s4;
	ctx_t               su_ctx_s4;
	logic               su_err_s4;
	logic [3:0]         su_neg_s4;
	logic [DEN_W-1:0]   su_dn_s4;
	logic [NUM_W-1:0]   su_n_s4 [4];

	assign su_ctx = rt_ctx_s[ROOT_W];

	always_comb begin
		su_dvq_c  = su_ctx.mode == MODE_INV || su_ctx.mode == MODE_QDIV ||
			su_ctx.mode == MODE_SDIVB;
		su_sext_c = {su_ctx.s[W-1], su_ctx.s};
		su_sabs_c = su_ctx.s[W-1] ? -su_sext_c : su_sext_c;
		case (su_ctx.mode)
			MODE_INV, MODE_QDIV, MODE_SDIVB: su_den_c = rt_dot_s[ROOT_W];
			MODE_ADIVS: su_den_c = (DEN_W-1)'(su_sabs_c);
			MODE_NORM: su_den_c = (DEN_W-1)'(rt_root_s[ROOT_W]);
			default: su_den_c = '0;
		endcase
		su_err_c = (su_dvq_c && rt_dot_s[ROOT_W] == '0) ||
			(su_ctx.mode == MODE_ADIVS && su_ctx.s == '0) ||
			(su_ctx.mode == MODE_NORM && rt_root_s[ROOT_W] == '0);
		for (int i = 0; i < 4; i++) begin
			case (su_ctx.mode)
				MODE_INV: begin
					su_v_c[i] = su_ctx.qa[i];
					su_f_c[i] = i < 3;
				end
				MODE_QDIV, MODE_SDIVB: begin
					su_v_c[i] = su_ctx.qb[i];
					su_f_c[i] = i < 3;
				end
				MODE_ADIVS: begin
					su_v_c[i] = su_ctx.qa[i];
					su_f_c[i] = su_ctx.s[W-1];
				end
				MODE_NORM: begin
					su_v_c[i] = su_ctx.qa[i];
					su_f_c[i] = 1'b0;
				end
				default: begin
					su_v_c[i] = '0;
					su_f_c[i] = 1'b0;
				end
			endcase
			su_c_c[i]   = su_f_c[i] ? -{su_v_c[i][W-1], su_v_c[i]} : {su_v_c[i][W-1], su_v_c[i]};
			su_mag_c[i] = su_c_c[i][W] ? -su_c_c[i] : su_c_c[i];
			su_num_c[i] = su_dvq_c ? NUM_W'(su_mag_c[i][W-1:0]) << (2 * F) :
				NUM_W'(su_mag_c[i][W-1:0]) << F;
			// rounding folded in: (2n + d) / 2d
			su_n_c[i]   = (su_num_c[i] << 1) + NUM_W'(su_den_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_v_s4 <= 1'b0;
		end else if (en) begin
			su_v_s4 <= rt_v_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			su_ctx_s4 <= su_ctx;
			su_err_s4 <= su_err_c;
			su_dn_s4  <= {su_den_c, 1'b0};
			for (int i = 0; i < 4; i++) begin
				su_neg_s4[i] <= su_c_c[i][W];
				su_n_s4[i]   <= su_n_c[i];
			end
		end
	end

	// divider pipe, four lanes sharing one divisor; index 0 checks for quotient overflow
	logic               dv_v_s   [QB+1];
	logic [REM_W-1:0]   dv_rem_s [QB+1][4];
	logic [QB-1:0]      dv_q_s   [QB+1][4];
	logic [3:0]         dv_ovf_s [QB+1];
	logic [3:0]         dv_neg_s [QB+1];
	logic [DEN_W-1:0]   dv_den_s [QB+1];
	logic               dv_err_s [QB+1];
	ctx_t               dv_ctx_s [QB+1];
	logic [REM_W-1:0]   dv_top_c;

	assign dv_top_c = REM_W'(su_dn_s4) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= su_v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				dv_rem_s[0][i] <= REM_W'(su_n_s4[i]);
				dv_q_s[0][i]   <= '0;
				dv_ovf_s[0][i] <= REM_W'(su_n_s4[i]) >= dv_top_c;
			end
			dv_neg_s[0] <= su_neg_s4;
			dv_den_s[0] <= su_dn_s4;
			dv_err_s[0] <= su_err_s4;
			dv_ctx_s[0] <= su_ctx_s4;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_dv
		localparam int SH = QB - j;
		logic [REM_W-1:0] dsh;
		logic [3:0]       take;

		assign dsh = REM_W'(dv_den_s[j-1]) << SH;

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				take[i] = dv_rem_s[j-1][i] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= dv_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					dv_rem_s[j][i] <= take[i] ? dv_rem_s[j-1][i] - dsh : dv_rem_s[j-1][i];
					dv_q_s[j][i]   <= dv_q_s[j-1][i] | ({{(QB-1){1'b0}}, take[i]} << SH);
				end
				dv_ovf_s[j] <= dv_ovf_s[j-1];
				dv_neg_s[j] <= dv_neg_s[j-1];
				dv_den_s[j] <= dv_den_s[j-1];
				dv_err_s[j] <= dv_err_s[j-1];
				dv_ctx_s[j] <= dv_ctx_s[j-1];
			end
		end
	end

	// stage 5: clamp quotients to the component range
	ctx_t           cl_ctx;
	logic [W-1:0]   cl_lim_c [4];
	logic [3:0]     cl_sat_c;
	logic [W-1:0]   cl_qc_c [4];
	logic [W-1:0]   cl_t_c [4];
	logic           cl_use_c;

	logic           cl_v_s5;
	ctx_t           cl_ctx_s5;
	logic           cl_err_s5;
	logic           cl_dsat_s5;
	logic [W-1:0]   cl_t_s5 [4];

	assign cl_ctx = dv_ctx_s[QB];

	always_comb begin
		cl_use_c = cl_ctx.mode == MODE_INV || cl_ctx.mode == MODE_QDIV ||
			cl_ctx.mode == MODE_ADIVS || cl_ctx.mode == MODE_SDIVB || cl_ctx.mode == MODE_NORM;
		for (int i = 0; i < 4; i++) begin
			cl_lim_c[i] = dv_neg_s[QB][i] ? LIM_NEG : LIM_POS;
			cl_sat_c[i] = dv_ovf_s[QB][i] || dv_q_s[QB][i] > cl_lim_c[i];
			cl_qc_c[i]  = cl_sat_c[i] ? cl_lim_c[i] : dv_q_s[QB][i];
			cl_t_c[i]   = dv_neg_s[QB][i] ? -cl_qc_c[i] : cl_qc_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_v_s5 <= 1'b0;
		end else if (en) begin
			cl_v_s5 <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cl_ctx_s5  <= cl_ctx;
			cl_err_s5  <= dv_err_s[QB];
			cl_dsat_s5 <= (|cl_sat_c) && cl_use_c;
			for (int i = 0; i < 4; i++) begin
				cl_t_s5[i] <= cl_t_c[i];
			end
		end
	end

	// stage 6: sixteen products, every mode expressed as signed sums of four products
	logic [3:0][W-1:0]        pq_c;
	logic [W-1:0]             pa_c [4][4];
	logic [W-1:0]             pb_c [4][4];
	logic [3:0]               sub_c [4];

	logic                     pr_v_s6;
	logic                     pr_err_s6;
	logic                     pr_dsat_s6;
	logic [3:0]               pr_sub_s6 [4];
	logic signed [PROD_W-1:0] pr_s6 [4][4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pq_c[i] = (cl_ctx_s5.mode == MODE_QDIV) ? cl_t_s5[i] : cl_ctx_s5.qb[i];
			sub_c[i] = 4'b0000;
			for (int k = 0; k < 4; k++) begin
				pa_c[i][k] = '0;
				pb_c[i][k] = '0;
			end
		end
		case (cl_ctx_s5.mode)
			MODE_MUL, MODE_QDIV: begin
				pa_c[0][0] = cl_ctx_s5.qa[0]; pb_c[0][0] = pq_c[3];
				pa_c[0][1] = cl_ctx_s5.qa[3]; pb_c[0][1] = pq_c[0];
				pa_c[0][2] = cl_ctx_s5.qa[1]; pb_c[0][2] = pq_c[2];
				pa_c[0][3] = cl_ctx_s5.qa[2]; pb_c[0][3] = pq_c[1];
				pa_c[1][0] = cl_ctx_s5.qa[1]; pb_c[1][0] = pq_c[3];
				pa_c[1][1] = cl_ctx_s5.qa[3]; pb_c[1][1] = pq_c[1];
				pa_c[1][2] = cl_ctx_s5.qa[2]; pb_c[1][2] = pq_c[0];
				pa_c[1][3] = cl_ctx_s5.qa[0]; pb_c[1][3] = pq_c[2];
				pa_c[2][0] = cl_ctx_s5.qa[2]; pb_c[2][0] = pq_c[3];
				pa_c[2][1] = cl_ctx_s5.qa[3]; pb_c[2][1] = pq_c[2];
				pa_c[2][2] = cl_ctx_s5.qa[0]; pb_c[2][2] = pq_c[1];
				pa_c[2][3] = cl_ctx_s5.qa[1]; pb_c[2][3] = pq_c[0];
				pa_c[3][0] = cl_ctx_s5.qa[3]; pb_c[3][0] = pq_c[3];
				pa_c[3][1] = cl_ctx_s5.qa[0]; pb_c[3][1] = pq_c[0];
				pa_c[3][2] = cl_ctx_s5.qa[1]; pb_c[3][2] = pq_c[1];
				pa_c[3][3] = cl_ctx_s5.qa[2]; pb_c[3][3] = pq_c[2];
				sub_c[0] = 4'b1000;
				sub_c[1] = 4'b1000;
				sub_c[2] = 4'b1000;
				sub_c[3] = 4'b1110;
			end
			MODE_ADD, MODE_SUB: begin
				for (int i = 0; i < 4; i++) begin
					pa_c[i][0] = cl_ctx_s5.qa[i]; pb_c[i][0] = ONE;
					pa_c[i][1] = cl_ctx_s5.qb[i]; pb_c[i][1] = ONE;
					sub_c[i] = (cl_ctx_s5.mode == MODE_SUB) ? 4'b0010 : 4'b0000;
				end
			end
			MODE_CONJ: begin
				for (int i = 0; i < 4; i++) begin
					pa_c[i][0] = cl_ctx_s5.qa[i]; pb_c[i][0] = ONE;
					sub_c[i] = (i < 3) ? 4'b0001 : 4'b0000;
				end
			end
			MODE_INV, MODE_ADIVS, MODE_NORM: begin
				for (int i = 0; i < 4; i++) begin
					pa_c[i][0] = cl_t_s5[i]; pb_c[i][0] = ONE;
				end
			end
			MODE_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					pa_c[i][0] = cl_ctx_s5.qa[i]; pb_c[i][0] = cl_ctx_s5.s;
				end
			end
			MODE_SDIVB: begin
				for (int i = 0; i < 4; i++) begin
					pa_c[i][0] = cl_ctx_s5.s; pb_c[i][0] = cl_t_s5[i];
				end
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					sub_c[i] = 4'b0000;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_v_s6 <= 1'b0;
		end else if (en) begin
			pr_v_s6 <= cl_v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_err_s6  <= cl_err_s5;
			pr_dsat_s6 <= cl_dsat_s5;
			for (int i = 0; i < 4; i++) begin
				pr_sub_s6[i] <= sub_c[i];
				for (int k = 0; k < 4; k++) begin
					pr_s6[i][k] <= $signed(pa_c[i][k]) * $signed(pb_c[i][k]);
				end
			end
		end
	end

	// stage 7: per-lane sums
	logic [SUM_W-1:0] sm_ext_c [4][4];
	logic [SUM_W-1:0] sm_c [4];

	logic             sm_v_s7;
	logic             sm_err_s7;
	logic             sm_dsat_s7;
	logic [SUM_W-1:0] sm_s7 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sm_c[i] = '0;
			for (int k = 0; k < 4; k++) begin
				sm_ext_c[i][k] = {{(SUM_W-PROD_W){pr_s6[i][k][PROD_W-1]}}, pr_s6[i][k]};
				sm_c[i] = pr_sub_s6[i][k] ? sm_c[i] - sm_ext_c[i][k] : sm_c[i] + sm_ext_c[i][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_v_s7 <= 1'b0;
		end else if (en) begin
			sm_v_s7 <= pr_v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_err_s7  <= pr_err_s6;
			sm_dsat_s7 <= pr_dsat_s6;
			for (int i = 0; i < 4; i++) begin
				sm_s7[i] <= sm_c[i];
			end
		end
	end

	// round to nearest, ties away from zero, then saturate
	logic             fi_neg_c [4];
	logic [SUM_W-1:0] fi_mag_c [4];
	logic [SUM_W-1:0] fi_rnd_c [4];
	logic [SUM_W-1:0] fi_lim_c [4];
	logic [W-1:0]     fi_val_c [4];
	logic [3:0]       fi_sat_c;
	qau_out_t         fin_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			fi_neg_c[i] = sm_s7[i][SUM_W-1];
			fi_mag_c[i] = fi_neg_c[i] ? -sm_s7[i] : sm_s7[i];
			fi_rnd_c[i] = (fi_mag_c[i] + HALF) >> F;
			fi_lim_c[i] = fi_neg_c[i] ? SUM_W'(LIM_NEG) : SUM_W'(LIM_POS);
			fi_sat_c[i] = fi_rnd_c[i] > fi_lim_c[i];
			if (fi_sat_c[i]) begin
				fi_rnd_c[i] = fi_lim_c[i];
			end
			fi_val_c[i] = fi_neg_c[i] ? -fi_rnd_c[i][W-1:0] : fi_rnd_c[i][W-1:0];
		end
		if (sm_err_s7) begin
			fin_c.r_x    = '0;
			fin_c.r_y    = '0;
			fin_c.r_z    = '0;
			fin_c.r_w    = '0;
			fin_c.status = ST_DIVZ;
		end else begin
			fin_c.r_x    = fi_val_c[0];
			fin_c.r_y    = fi_val_c[1];
			fin_c.r_z    = fi_val_c[2];
			fin_c.r_w    = fi_val_c[3];
			fin_c.status = ((|fi_sat_c) || sm_dsat_s7) ? ST_SAT : ST_OK;
		end
	end

	// output register with one skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (skid_v_q) begin
			if (res_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (sm_v_s7) begin
			if (!res_valid_q || res_ready) begin
				res_valid_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (res_ready) begin
				res_q <= skid_q;
			end
		end else if (sm_v_s7) begin
			if (!res_valid_q || res_ready) begin
				res_q <= fin_c;
			end else begin
				skid_q <= fin_c;
			end
		end
	end

`ifndef ASSERT_OFF
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status == ST_DIVZ |->
		res_data.r_x == '0 && res_data.r_y == '0 && res_data.r_z == '0 && res_data.r_w == '0)
		else $error("divide-by-zero word carries nonzero data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.status == ST_OK || res_data.status == ST_SAT ||
		res_data.status == ST_DIVZ)
		else $error("unused status code on result");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_valid_q)
		else $error("skid word held with empty output register");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !res_ready |=> skid_v_q)
		else $error("skid word dropped while output stalled");

	a_err_mode: assert property (@(posedge clk) disable iff (!arst_n)
		su_v_s4 && su_err_s4 |-> su_ctx_s4.mode == MODE_INV || su_ctx_s4.mode == MODE_QDIV ||
		su_ctx_s4.mode == MODE_ADIVS || su_ctx_s4.mode == MODE_SDIVB ||
		su_ctx_s4.mode == MODE_NORM)
		else $error("zero divisor flagged on a mode without division");
`endif

endmodule

`default_nettype wire
